// ----- design/lcs_pkg.sv -----
// Shared types and constants for the longest common substring block.
// Holds the opcode codes, the controller state type and the command and
// status structs between controller and datapath. Depends on nothing.
package lcs_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_LEN_DEF     = 64;
    localparam int SYMBOL_BITS_DEF = 8;

    // Fixed field widths of the stream words.
    localparam int OPCODE_W   = 2;
    localparam int SYMBOL_W   = 8;
    localparam int LENGTH_W   = 7;
    localparam int START_W    = 6;
    localparam int OUT_DATA_W = 16;

    localparam logic [OPCODE_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_COMPUTE       = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_RD,
        S_CELL_RD,
        S_CELL_UPD,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic append_first;
        logic append_second;
        logic start;
        logic read_row;
        logic read_cell;
        logic update_cell;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic col_last;
        logic row_last;
        logic out_busy;
    } status_t;

endpackage

// ----- design/longest_common_substring_top.sv -----
// Top level of the longest common substring block.
// Joins lcs_ctrl and lcs_datapath; uses lcs_pkg for types and defaults.
//
// The block takes words on the slave stream, each carrying an opcode in
// s_tuser and a symbol in s_tdata. Opcodes 0 and 1 append the symbol to the
// first or second sequence; a symbol sent to a full sequence is dropped.
// Opcode 2 starts a search for the longest contiguous run common to both
// sequences and then empties them; opcode 3 is ignored. The search walks
// the second sequence row by row and the first sequence column by column,
// with a row-read state per row to fetch the row symbol and a read state
// and an update state per table cell, because each cell reads the symbol
// store and the run table through their registered read ports and then
// writes the run table; with either sequence empty the walk is skipped.
// s_tready is low throughout the search. Each search yields exactly one
// master word holding the run length (zero when nothing matches) and its
// start in the first sequence; on equal lengths the first run met in scan
// order wins. The result sits in an output register, so appends are taken
// while it waits. No clearing pass is needed after reset.
module longest_common_substring_top #(
    parameter int MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcs_pkg::SYMBOL_W-1:0]    s_tdata,   // [7:0] symbol
    input  logic [lcs_pkg::OPCODE_W-1:0]    s_tuser,   // [1:0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcs_pkg::OUT_DATA_W-1:0]  m_tdata    // [6:0] match_length,
                                                       // [12:7] match_start
);

    lcs_pkg::cmd_t    cmd;
    lcs_pkg::status_t status;

    lcs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser),
        .in_ready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lcs_datapath #(
        .MAX_LEN     (MAX_LEN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_symbol (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ----- design/lcs_ctrl.sv -----
// Controller state machine of the longest common substring block.
// Sequences loads, the table walk and the result hand-off; uses lcs_pkg.
module lcs_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [lcs_pkg::OPCODE_W-1:0]  in_opcode,
    output logic                          in_ready,
    input  lcs_pkg::status_t              status,
    output lcs_pkg::cmd_t                 cmd
);

    lcs_pkg::state_t state_reg;
    lcs_pkg::state_t state_next;
    logic            accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcs_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lcs_pkg::S_IDLE: begin
                if (accept && in_opcode == lcs_pkg::OP_COMPUTE) begin
                    state_next = status.empty ? lcs_pkg::S_RESULT : lcs_pkg::S_ROW_RD;
                end
            end
            lcs_pkg::S_ROW_RD: begin
                state_next = lcs_pkg::S_CELL_RD;
            end
            lcs_pkg::S_CELL_RD: begin
                state_next = lcs_pkg::S_CELL_UPD;
            end
            lcs_pkg::S_CELL_UPD: begin
                if (!status.col_last) begin
                    state_next = lcs_pkg::S_CELL_RD;
                end else if (status.row_last) begin
                    state_next = lcs_pkg::S_RESULT;
                end else begin
                    state_next = lcs_pkg::S_ROW_RD;
                end
            end
            lcs_pkg::S_RESULT: begin
                if (!status.out_busy) begin
                    state_next = lcs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lcs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            lcs_pkg::S_IDLE: begin
                in_ready          = 1'b1;
                cmd.append_first  = accept && in_opcode == lcs_pkg::OP_APPEND_FIRST;
                cmd.append_second = accept && in_opcode == lcs_pkg::OP_APPEND_SECOND;
                cmd.start         = accept && in_opcode == lcs_pkg::OP_COMPUTE;
            end
            lcs_pkg::S_ROW_RD: begin
                cmd.read_row = 1'b1;
            end
            lcs_pkg::S_CELL_RD: begin
                cmd.read_cell = 1'b1;
            end
            lcs_pkg::S_CELL_UPD: begin
                cmd.update_cell = 1'b1;
            end
            lcs_pkg::S_RESULT: begin
                cmd.load_result = !status.out_busy;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/lcs_datapath.sv -----
// Datapath of the longest common substring block: symbol stores, run table,
// walk counters, best-run tracking and the output register. Uses lcs_pkg.
module lcs_datapath #(
    parameter int MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [lcs_pkg::SYMBOL_W-1:0]    in_symbol,
    input  lcs_pkg::cmd_t                   cmd,
    output lcs_pkg::status_t                status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lcs_pkg::OUT_DATA_W-1:0]  out_data
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [SYMBOL_BITS-1:0] first_mem  [MAX_LEN];
    logic [SYMBOL_BITS-1:0] second_mem [MAX_LEN];
    logic [LEN_W-1:0]       prev_mem   [MAX_LEN];

    logic [LEN_W-1:0]       first_count_reg;
    logic [LEN_W-1:0]       second_count_reg;
    logic [IDX_W-1:0]       row_reg;
    logic [IDX_W-1:0]       col_reg;
    logic [SYMBOL_BITS-1:0] row_sym_reg;
    logic [SYMBOL_BITS-1:0] col_sym_reg;
    logic [LEN_W-1:0]       prev_q_reg;
    logic [LEN_W-1:0]       diag_reg;
    logic [LEN_W-1:0]       best_len_reg;
    logic [IDX_W-1:0]       best_end_reg;
    logic                   out_valid_reg;
    logic [lcs_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [SYMBOL_BITS+lcs_pkg::SYMBOL_W-1:0] sym_wide;
    logic [SYMBOL_BITS-1:0] sym_in;
    logic                   first_full;
    logic                   second_full;
    logic [LEN_W-1:0]       col_plus;
    logic [LEN_W-1:0]       row_plus;
    logic [LEN_W-1:0]       old_here;
    logic [LEN_W-1:0]       old_diag;
    logic [LEN_W-1:0]       run;
    logic [IDX_W-1:0]       start_idx;
    logic [LEN_W+lcs_pkg::LENGTH_W-1:0] len_wide;
    logic [IDX_W+lcs_pkg::START_W-1:0]  start_wide;

    // Keep the low SYMBOL_BITS of the symbol, zero-extended if wider.
    assign sym_wide = {{SYMBOL_BITS{1'b0}}, in_symbol};
    assign sym_in   = sym_wide[SYMBOL_BITS-1:0];

    assign first_full  = first_count_reg == LEN_W'(MAX_LEN);
    assign second_full = second_count_reg == LEN_W'(MAX_LEN);
    assign col_plus    = LEN_W'(col_reg) + LEN_W'(1);
    assign row_plus    = LEN_W'(row_reg) + LEN_W'(1);

    assign status.empty    = first_count_reg == '0 || second_count_reg == '0;
    assign status.col_last = col_plus == first_count_reg;
    assign status.row_last = row_plus == second_count_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    // The first row sees an all-zero previous row, so the table needs no clearing.
    assign old_here = (row_reg == '0) ? '0 : prev_q_reg;
    assign old_diag = (col_reg == '0 || row_reg == '0) ? '0 : diag_reg;
    assign run      = (row_sym_reg == col_sym_reg) ? old_diag + LEN_W'(1) : '0;

    assign start_idx  = (best_len_reg == '0) ? '0
                      : best_end_reg + IDX_W'(1) - IDX_W'(best_len_reg);
    assign len_wide   = {{lcs_pkg::LENGTH_W{1'b0}}, best_len_reg};
    assign start_wide = {{lcs_pkg::START_W{1'b0}}, start_idx};

    always_ff @(posedge aclk) begin
        if (cmd.append_first && !first_full) begin
            first_mem[first_count_reg[IDX_W-1:0]] <= sym_in;
        end
        if (cmd.append_second && !second_full) begin
            second_mem[second_count_reg[IDX_W-1:0]] <= sym_in;
        end
        if (cmd.update_cell) begin
            prev_mem[col_reg] <= run;
        end
        if (cmd.read_row) begin
            row_sym_reg <= second_mem[row_reg];
        end
        if (cmd.read_cell) begin
            col_sym_reg <= first_mem[col_reg];
            prev_q_reg  <= prev_mem[col_reg];
        end
        if (cmd.update_cell) begin
            diag_reg <= old_here;
        end
        if (cmd.load_result) begin
            out_data_reg <= {{(lcs_pkg::OUT_DATA_W - lcs_pkg::LENGTH_W - lcs_pkg::START_W){1'b0}},
                             start_wide[lcs_pkg::START_W-1:0],
                             len_wide[lcs_pkg::LENGTH_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            best_len_reg     <= '0;
            best_end_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cmd.append_first && !first_full) begin
                first_count_reg <= first_count_reg + LEN_W'(1);
            end
            if (cmd.append_second && !second_full) begin
                second_count_reg <= second_count_reg + LEN_W'(1);
            end
            if (cmd.start) begin
                row_reg      <= '0;
                col_reg      <= '0;
                best_len_reg <= '0;
                best_end_reg <= '0;
            end
            if (cmd.update_cell) begin
                if (run > best_len_reg) begin
                    best_len_reg <= run;
                    best_end_reg <= col_reg;
                end
                if (status.col_last) begin
                    col_reg <= '0;
                    row_reg <= row_reg + IDX_W'(1);
                end else begin
                    col_reg <= col_reg + IDX_W'(1);
                end
            end
            if (cmd.load_result) begin
                first_count_reg  <= '0;
                second_count_reg <= '0;
                out_valid_reg    <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        first_count_reg <= LEN_W'(MAX_LEN) && second_count_reg <= LEN_W'(MAX_LEN))
        else $error("sequence count beyond capacity");

    a_counts_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |=> first_count_reg == '0 && second_count_reg == '0)
        else $error("sequences not emptied after result");

    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.start |=> best_len_reg >= $past(best_len_reg))
        else $error("best run shrank during a search");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.load_result))
        else $error("result raised without a load");

endmodule
